>>> src/eypr_pkg.sv
// Package for the yaw-pitch-roll to pose matrix block.
// Holds CORDIC constants, the arctangent table and shared types. No dependencies.
`default_nettype none
package eypr_pkg;
  localparam int CordicStagesDefault = 16;
  localparam int TableLen = 24;
  localparam int AngW = 16;
  localparam int CordW = 34;
  localparam int ZW = 26;
  localparam int EntW = 16;
  localparam int TrW = 32;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [EntW-1:0] UnitQ14 = 16'sd16384;
  localparam logic signed [AngW:0] HalfTurn = 17'sd23040;
  localparam logic signed [AngW:0] QuarterTurn = 17'sd11520;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0] z;
    logic neg;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 26'sd2949120;  1: t = 26'sd1740967;  2: t = 26'sd919879;
      3: t = 26'sd466945;   4: t = 26'sd234379;   5: t = 26'sd117304;
      6: t = 26'sd58666;    7: t = 26'sd29335;    8: t = 26'sd14668;
      9: t = 26'sd7334;     10: t = 26'sd3667;    11: t = 26'sd1833;
      12: t = 26'sd917;     13: t = 26'sd458;     14: t = 26'sd229;
      15: t = 26'sd115;     16: t = 26'sd57;      17: t = 26'sd29;
      18: t = 26'sd14;      19: t = 26'sd7;       20: t = 26'sd4;
      21: t = 26'sd2;       22: t = 26'sd1;       default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [EntW-1:0] clamp_wide(input logic signed [47:0] v);
    if (v > 48'sd16384) return UnitQ14;
    if (v < -48'sd16384) return -UnitQ14;
    return v[EntW-1:0];
  endfunction
endpackage
`default_nettype wire

>>> src/eypr_cell.sv
// One CORDIC micro-rotation cell, registered; a row of these forms the sin/cos chain.
// Depends on eypr_pkg.
`default_nettype none
module eypr_cell import eypr_pkg::*; #(
  parameter int Idx = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cvec_t [2:0] din,
  output cvec_t [2:0] dout
);
  cvec_t [2:0] nxt;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k].neg = din[k].neg;
      if (!din[k].z[ZW-1]) begin
        nxt[k].x = din[k].x - (din[k].y >>> Idx);
        nxt[k].y = din[k].y + (din[k].x >>> Idx);
        nxt[k].z = din[k].z - atan_deg(Idx);
      end else begin
        nxt[k].x = din[k].x + (din[k].y >>> Idx);
        nxt[k].y = din[k].y - (din[k].x >>> Idx);
        nxt[k].z = din[k].z + atan_deg(Idx);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

>>> src/eypr_matrix.sv
// Matrix stage: rounds CORDIC outputs and forms the nine rotation entries in
// registered steps. Depends on eypr_pkg.
`default_nettype none
module eypr_matrix import eypr_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire cvec_t [2:0] din,
  output logic signed [EntW-1:0] r [9]
);
  logic signed [EntW-1:0] s [3], c [3];
  logic signed [31:0] pa [9];
  logic signed [EntW-1:0] sq [3], cq [3];
  logic signed [47:0] q [9];

  function automatic logic signed [EntW-1:0] rnd(input logic signed [CordW-1:0] v,
                                                 input logic neg);
    logic signed [CordW-1:0] t;
    logic signed [EntW-1:0] m;
    t = (v + 34'sd32768) >>> 16;
    m = clamp_wide(48'(t));
    return neg ? -m : m;
  endfunction

  function automatic logic signed [31:0] c_s(input logic signed [EntW-1:0] a,
                                             input logic signed [EntW-1:0] b);
    return a * b;
  endfunction

  // step 1: sin/cos in Q2.14; yaw=0 pitch=1 roll=2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c[k] <= rnd(din[k].x, din[k].neg);
        s[k] <= rnd(din[k].y, din[k].neg);
      end
    end
  end
  // step 2: pairwise products (Q28)
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= c[0] * c[1];
      pa[1] <= c[0] * s[1];
      pa[2] <= s[0] * c[2];
      pa[3] <= s[0] * c[1];
      pa[4] <= s[0] * s[1];
      pa[5] <= c[0] * c[2];
      pa[6] <= s[0] * s[2];
      pa[7] <= c[1] * s[2];
      pa[8] <= c[1] * c[2];
      for (int k = 0; k < 3; k++) begin
        sq[k] <= s[k];
        cq[k] <= c[k];
      end
    end
  end
  // step 3: third factor and Q42 sums for entries 1, 2, 4, 5; the others pass on in Q28 or Q14
  always_ff @(posedge clk) begin
    if (en) begin
      q[0] <= 48'(pa[0]);
      q[1] <= 48'(pa[1]) * sq[2] - (48'(pa[2]) <<< 14);
      q[2] <= 48'(pa[1]) * cq[2] + (48'(pa[6]) <<< 14);
      q[3] <= 48'(pa[3]);
      q[4] <= 48'(pa[4]) * sq[2] + (48'(pa[5]) <<< 14);
      q[5] <= 48'(pa[4]) * cq[2] - (48'(c_s(cq[0], sq[2])) <<< 14);
      q[6] <= 48'(-sq[1]);
      q[7] <= 48'(pa[7]);
      q[8] <= 48'(pa[8]);
    end
  end
  // step 4: round and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= clamp_wide((q[0] + 48'sd8192) >>> 14);
      r[3] <= clamp_wide((q[3] + 48'sd8192) >>> 14);
      r[7] <= clamp_wide((q[7] + 48'sd8192) >>> 14);
      r[8] <= clamp_wide((q[8] + 48'sd8192) >>> 14);
      r[6] <= clamp_wide(q[6]);
      r[1] <= clamp_wide((q[1] + 48'sd134217728) >>> 28);
      r[2] <= clamp_wide((q[2] + 48'sd134217728) >>> 28);
      r[4] <= clamp_wide((q[4] + 48'sd134217728) >>> 28);
      r[5] <= clamp_wide((q[5] + 48'sd134217728) >>> 28);
    end
  end
endmodule
`default_nettype wire

>>> src/euler_ypr_to_pose_matrix.sv
// Top level of the yaw-pitch-roll to pose matrix block.
// Depends on eypr_pkg, eypr_cell, eypr_matrix.
//
// Accepts one pose per cycle and returns its 3x4 transform through a pipeline of one
// range-reduction register, one CORDIC cell per stage (min(CORDIC_STAGES,24) cells),
// and four matrix steps. The whole path is one pipeline that advances when the
// output register is empty or being taken, so throughput is one transaction per cycle.
`default_nettype none
module euler_ypr_to_pose_matrix import eypr_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // yaw, pitch, roll (16 each), trans_x, trans_y, trans_z (32 each)
  input  wire logic [143:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // r00,r01,r02,r10,r11,r12,r20,r21,r22 (16 each), out_tx, out_ty, out_tz (32 each)
  output logic [239:0] m_tdata
);
  localparam int N = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int Lat = N + 5;

  logic en;
  logic [Lat-1:0] vld;
  logic [3*TrW-1:0] tr [Lat];
  cvec_t [2:0] chain [N+1];
  logic signed [EntW-1:0] r [9];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_tvalid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tr[0] <= s_tdata[143:48];
      for (int k = 1; k < Lat; k++) tr[k] <= tr[k-1];
    end
  end

  // range reduction into the first chain slot
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [AngW:0] a;
        a = 17'(signed'(s_tdata[16*k +: 16]));
        if (a >= HalfTurn) a = a - 17'sd46080;
        if (a < -HalfTurn) a = a + 17'sd46080;
        chain[0][k].neg <= (a > QuarterTurn) || (a < -QuarterTurn);
        if (a > QuarterTurn) a = a - HalfTurn;
        else if (a < -QuarterTurn) a = a + HalfTurn;
        chain[0][k].z <= ZW'(a) <<< 9;
        chain[0][k].x <= GainQ30;
        chain[0][k].y <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    eypr_cell #(.Idx(i)) u_cell (.clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  eypr_matrix u_mat (.clk(clk), .en(en), .din(chain[N]), .r(r));

  assign m_tdata = {tr[Lat-1], r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");
  a_r20: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[111:96]) <= 16'sd16384)
                 && ($signed(m_tdata[111:96]) >= -16'sd16384))
    else $error("entry out of unit range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("stalled with empty output");
endmodule
`default_nettype wire
